// ===== hw/rtl/dhfr_pkg.sv =====
package dhfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;

    localparam logic KIND_DISP = 1'b0;
    localparam logic KIND_CAM  = 1'b1;

    localparam logic [BYTE_W-1:0] DISP_SYNC0 = 8'hAA;
    localparam logic [BYTE_W-1:0] DISP_SYNC1 = 8'h55;
    localparam logic [BYTE_W-1:0] CAM_SYNC   = 8'h40;
    localparam logic [BYTE_W-1:0] CAM_TAG    = 8'h63;

    typedef struct packed {
        logic              frame_kind;
        logic [BYTE_W-1:0] out_byte;
        logic [CNT_W-1:0]  byte_index;
        logic              is_last;
        logic [CNT_W-1:0]  frame_length;
    } result_t;

endpackage

// ===== hw/rtl/dhfr_if.sv =====
interface dhfr_rx_if
    import dhfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dhfr_res_if
    import dhfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              frame_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  byte_index;
    logic              is_last;
    logic [CNT_W-1:0]  frame_length;

    modport source (output valid, output frame_kind, output out_byte, output byte_index,
                    output is_last, output frame_length, input ready);
    modport sink (input valid, input frame_kind, input out_byte, input byte_index,
                  input is_last, input frame_length, output ready);
endinterface

// ===== hw/rtl/dual_header_frame_receiver_core.sv =====
// Serial frame receiver for two frame types. A display frame (AA 55 L body) is
// passed out whole, header included, and ends on byte L+3 but never before its
// fourth byte. A camera frame (40 40 63 x x lo hi x) has its 8-byte header
// consumed and its max(P,1) payload bytes passed out, P being the little-endian
// length masked to LENGTH_BITS bits. Any other lead bytes are dropped. Each
// output transaction carries the byte, its kind, its index in the frame, a last
// flag and, on the last byte, the frame length. A byte passes an input register
// and then a result register, and one byte is taken per clock while the result
// side keeps up. The byte that completes a display header yields three
// transactions, drained one per clock while the result side is ready, from the
// single result register; the input register holds the next byte meanwhile.
module dual_header_frame_receiver_core
    import dhfr_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    dhfr_rx_if.sink    rx,
    dhfr_res_if.source res
);

    localparam int CW1 = CNT_W + 1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_DISP = 2'd1;
    localparam logic [1:0] MODE_CAM  = 2'd2;

    localparam logic [1:0] BURST_NONE = 2'd0;
    localparam logic [1:0] BURST_LEN  = 2'd1;
    localparam logic [1:0] BURST_SYNC = 2'd2;

    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic [1:0]             mode_reg, mode_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LENGTH_BITS-1:0] exp_len_reg, exp_len_next;
    logic [BYTE_W-1:0]      hdr_reg [3];
    logic [BYTE_W-1:0]      len_lo_reg;
    logic [BYTE_W-1:0]      len_hi_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    logic [1:0]             burst_reg;

    logic [CW1-1:0]         cnt;
    logic [CW1-1:0]         exp_ext;
    logic [CNT_W-1:0]       cam_len;
    logic [BYTE_W-1:0]      h0;
    logic                   last;
    logic                   out_free;
    logic                   consume;
    logic                   emit;
    logic [1:0]             burst_next;
    result_t                res_next;

    assign out_free = !out_valid_reg || (res.ready && burst_reg == BURST_NONE);
    assign consume  = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || consume;

    assign cnt     = {1'b0, count_reg} + CW1'(1);
    assign exp_ext = CW1'(exp_len_reg);
    assign cam_len = {len_hi_reg, len_lo_reg};
    assign h0      = (count_reg == '0) ? in_byte_reg : hdr_reg[0];

    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = cnt[CNT_W-1:0];
        exp_len_next = exp_len_reg;
        emit         = 1'b0;
        burst_next   = BURST_NONE;
        last         = 1'b0;
        res_next     = '0;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                priority if (h0 != DISP_SYNC0 && h0 != CAM_SYNC)
                begin
                    count_next = '0;
                end
                else if (cnt == CW1'(2))
                begin
                    if (in_byte_reg != DISP_SYNC1 && in_byte_reg != CAM_SYNC)
                        count_next = '0;
                end
                else if (cnt == CW1'(3))
                begin
                    if (h0 == DISP_SYNC0 && hdr_reg[1] == DISP_SYNC1)
                    begin
                        mode_next           = MODE_DISP;
                        exp_len_next        = LENGTH_BITS'(in_byte_reg);
                        emit                = 1'b1;
                        burst_next          = BURST_SYNC;
                        res_next.frame_kind = KIND_DISP;
                        res_next.out_byte   = h0;
                    end
                    else if (h0 != CAM_SYNC)
                    begin
                        count_next = '0;
                    end
                end
                else if (cnt >= CW1'(8))
                begin
                    if (hdr_reg[0] == CAM_SYNC && hdr_reg[1] == CAM_SYNC && hdr_reg[2] == CAM_TAG)
                    begin
                        mode_next    = MODE_CAM;
                        exp_len_next = cam_len[LENGTH_BITS-1:0];
                    end
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt[CNT_W-1:0];
                end
            end
            MODE_DISP:
            begin
                last                  = cnt >= exp_ext + CW1'(3);
                emit                  = 1'b1;
                res_next.frame_kind   = KIND_DISP;
                res_next.out_byte     = in_byte_reg;
                res_next.byte_index   = count_reg;
                res_next.is_last      = last;
                res_next.frame_length = last ? cnt[CNT_W-1:0] : '0;
                if (last)
                begin
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            MODE_CAM:
            begin
                last                  = cnt >= exp_ext;
                emit                  = 1'b1;
                res_next.frame_kind   = KIND_CAM;
                res_next.out_byte     = in_byte_reg;
                res_next.byte_index   = count_reg;
                res_next.is_last      = last;
                res_next.frame_length = last ? CNT_W'(exp_len_reg) : '0;
                if (last)
                begin
                    count_next = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next  = MODE_IDLE;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            exp_len_reg   <= '0;
            out_valid_reg <= 1'b0;
            burst_reg     <= BURST_NONE;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (consume)
            begin
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                exp_len_reg <= exp_len_next;
            end
            if (consume && emit)
            begin
                out_valid_reg <= 1'b1;
                burst_reg     <= burst_next;
            end
            else if (out_valid_reg && res.ready)
            begin
                if (burst_reg != BURST_NONE)
                    burst_reg <= burst_reg - 2'd1;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (consume && mode_reg == MODE_IDLE)
        begin
            unique case (count_reg[2:0])
                3'd0:    hdr_reg[0] <= in_byte_reg;
                3'd1:    hdr_reg[1] <= in_byte_reg;
                3'd2:    hdr_reg[2] <= in_byte_reg;
                3'd5:    len_lo_reg <= in_byte_reg;
                3'd6:    len_hi_reg <= in_byte_reg;
                default: ;
            endcase
        end
        if (consume && emit)
        begin
            out_reg <= res_next;
        end
        else if (out_valid_reg && res.ready && burst_reg != BURST_NONE)
        begin
            out_reg.out_byte   <= (burst_reg == BURST_LEN) ? hdr_reg[2] : hdr_reg[1];
            out_reg.byte_index <= out_reg.byte_index + CNT_W'(1);
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.frame_kind   = out_reg.frame_kind;
    assign res.out_byte     = out_reg.out_byte;
    assign res.byte_index   = out_reg.byte_index;
    assign res.is_last      = out_reg.is_last;
    assign res.frame_length = out_reg.frame_length;

endmodule

// ===== hw/rtl/dhfr_checker.sv =====
module dhfr_checker
    import dhfr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic             frame_kind,
    input logic [CNT_W-1:0] byte_index,
    input logic             is_last,
    input logic [CNT_W-1:0] frame_length
);

    logic             open_reg;
    logic             kind_reg;
    logic [CNT_W-1:0] index_reg;
    logic             xfer;

    assign xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            kind_reg  <= KIND_DISP;
            index_reg <= '0;
        end
        else if (xfer)
        begin
            open_reg  <= !is_last;
            kind_reg  <= frame_kind;
            index_reg <= byte_index;
        end
    end

    a_len_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> frame_length == '0)
        else $error("frame_length set on a byte that is not last");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && open_reg |-> byte_index == index_reg + CNT_W'(1) && frame_kind == kind_reg)
        else $error("byte_index or kind broke within a frame");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !open_reg |-> byte_index == '0)
        else $error("frame did not start at index zero");

    a_disp_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last && frame_kind == KIND_DISP |->
            frame_length == byte_index + CNT_W'(1))
        else $error("display frame length disagrees with its last index");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind dual_header_frame_receiver_core dhfr_checker u_dhfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .frame_kind   (res.frame_kind),
    .byte_index   (res.byte_index),
    .is_last      (res.is_last),
    .frame_length (res.frame_length)
);

// ===== tb/dhfr_frame_checker.sv =====
module dhfr_frame_checker
    import dhfr_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    dhfr_rx_if   rx,
    dhfr_res_if  res,
    output int   mismatch_count,
    output int   outstanding
);

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_DISPLAY,
        PARSE_CAMERA
    } parse_mode_e;

    localparam logic [CNT_W-1:0] LENGTH_MASK = CNT_W'((32'd1 << LENGTH_BITS) - 32'd1);

    parse_mode_e       parse_mode = PARSE_IDLE;
    logic [CNT_W-1:0]  byte_count = '0;
    logic [CNT_W-1:0]  expected_length = '0;
    logic [BYTE_W-1:0] header_bytes [8];

    result_t expected_frame_bytes [$];
    int      errors_seen = 0;
    int      queued_count = 0;

    assign mismatch_count = errors_seen;
    assign outstanding    = queued_count;

    task automatic queue_frame_byte(input logic kind, input logic [BYTE_W-1:0] value,
                                    input logic [CNT_W-1:0] index, input logic last,
                                    input logic [CNT_W-1:0] length);
        result_t r;
        r.frame_kind   = kind;
        r.out_byte     = value;
        r.byte_index   = index;
        r.is_last      = last;
        r.frame_length = length;
        expected_frame_bytes.push_back(r);
    endtask

    task automatic advance_frame_parser(input logic [BYTE_W-1:0] value);
        logic [CNT_W:0] next_count;
        logic           last;
        next_count = {1'b0, byte_count} + 1'b1;
        case (parse_mode)
            PARSE_IDLE:
            begin
                header_bytes[byte_count[2:0]] = value;
                if (header_bytes[0] != DISP_SYNC0 && header_bytes[0] != CAM_SYNC)
                begin
                    next_count = '0;
                end
                else if (next_count == 2)
                begin
                    if (header_bytes[1] != DISP_SYNC1 && header_bytes[1] != CAM_SYNC)
                    begin
                        next_count = '0;
                    end
                end
                else if (next_count == 3)
                begin
                    if (header_bytes[0] == DISP_SYNC0 && header_bytes[1] == DISP_SYNC1)
                    begin
                        expected_length = {8'h00, header_bytes[2]};
                        parse_mode = PARSE_DISPLAY;
                        queue_frame_byte(KIND_DISP, header_bytes[0], 16'd0, 1'b0, '0);
                        queue_frame_byte(KIND_DISP, header_bytes[1], 16'd1, 1'b0, '0);
                        queue_frame_byte(KIND_DISP, header_bytes[2], 16'd2, 1'b0, '0);
                    end
                    else if (header_bytes[0] != CAM_SYNC)
                    begin
                        next_count = '0;
                    end
                end
                else if (next_count >= 8)
                begin
                    if (header_bytes[0] == CAM_SYNC && header_bytes[1] == CAM_SYNC
                        && header_bytes[2] == CAM_TAG)
                    begin
                        expected_length = {header_bytes[6], header_bytes[5]} & LENGTH_MASK;
                        parse_mode = PARSE_CAMERA;
                    end
                    next_count = '0;
                end
                byte_count = next_count[CNT_W-1:0];
            end
            PARSE_DISPLAY:
            begin
                last = next_count >= {1'b0, expected_length} + 17'd3;
                queue_frame_byte(KIND_DISP, value, byte_count, last,
                                 last ? next_count[CNT_W-1:0] : '0);
                if (last)
                begin
                    next_count = '0;
                    parse_mode = PARSE_IDLE;
                end
                byte_count = next_count[CNT_W-1:0];
            end
            PARSE_CAMERA:
            begin
                last = next_count >= {1'b0, expected_length};
                queue_frame_byte(KIND_CAM, value, byte_count, last,
                                 last ? expected_length : '0);
                if (last)
                begin
                    next_count = '0;
                    parse_mode = PARSE_IDLE;
                end
                byte_count = next_count[CNT_W-1:0];
            end
            default:
            begin
                parse_mode = PARSE_IDLE;
                byte_count = '0;
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            errors_seen++;
        end
    endtask

    task automatic check_frame_byte();
        result_t want;
        if (expected_frame_bytes.size() == 0)
        begin
            $display("%0t: unexpected transaction: expected none, actual byte %0h index %0d",
                     $time, res.out_byte, res.byte_index);
            errors_seen++;
        end
        else
        begin
            want = expected_frame_bytes.pop_front();
            compare_field("frame_kind", CNT_W'(want.frame_kind), CNT_W'(res.frame_kind));
            compare_field("out_byte", CNT_W'(want.out_byte), CNT_W'(res.out_byte));
            compare_field("byte_index", want.byte_index, res.byte_index);
            compare_field("is_last", CNT_W'(want.is_last), CNT_W'(res.is_last));
            compare_field("frame_length", want.frame_length, res.frame_length);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                advance_frame_parser(rx.rx_byte);
            end
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                check_frame_byte();
            end
            queued_count <= expected_frame_bytes.size();
        end
    end

endmodule

// ===== tb/tb_dual_header_frame_receiver_core.sv =====
module tb_dual_header_frame_receiver_core;
    import dhfr_pkg::*;

    localparam int LENGTH_BITS  = 16;
    localparam int RANDOM_BYTES = 120;

    logic clk = 1'b0;
    logic rst_n;

    dhfr_rx_if  rx_if();
    dhfr_res_if res_if();

    int mismatch_count;
    int outstanding;
    int burst_left = 0;
    int frame_bytes_sent = 0;
    int stall_style = 0;
    int stall_phase_left = 0;

    logic [BYTE_W-1:0] directed_bytes [0:25] = '{
        DISP_SYNC0, DISP_SYNC1, 8'h00, 8'hFF,
        DISP_SYNC0, DISP_SYNC0,
        DISP_SYNC0, CAM_SYNC, 8'h00,
        CAM_SYNC, CAM_SYNC, CAM_TAG, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h5A,
        CAM_SYNC, DISP_SYNC1, CAM_TAG, 8'h12, 8'h34, 8'h01, 8'h00, 8'h9C
    };

    dual_header_frame_receiver_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_if),
        .res  (res_if)
    );

    dhfr_frame_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_if),
        .res           (res_if),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_style      <= $urandom_range(0, 2);
            stall_phase_left <= $urandom_range(8, 64);
        end
        else
        begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_style)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        do @(posedge clk); while (rx_if.ready !== 1'b1);
        burst_left--;
    endtask

    task automatic send_display(input int length);
        int body;
        body = (length < 1) ? 1 : length;
        send_byte(DISP_SYNC0);
        send_byte(DISP_SYNC1);
        send_byte(BYTE_W'(length));
        repeat (body) send_byte(BYTE_W'($urandom));
        frame_bytes_sent += 3 + body;
    endtask

    task automatic send_camera(input int length);
        int payload;
        payload = (length < 1) ? 1 : length;
        send_byte(CAM_SYNC);
        send_byte(CAM_SYNC);
        send_byte(CAM_TAG);
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'(length));
        send_byte(BYTE_W'(length >> 8));
        send_byte(BYTE_W'($urandom));
        repeat (payload) send_byte(BYTE_W'($urandom));
        frame_bytes_sent += 8 + payload;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
            1:
            begin
                send_byte(DISP_SYNC0);
                send_byte(BYTE_W'($urandom));
            end
            2:
            begin
                send_byte(DISP_SYNC0);
                send_byte(CAM_SYNC);
                send_byte(BYTE_W'($urandom));
            end
            default:
            begin
                send_byte(CAM_SYNC);
                send_byte(($urandom_range(0, 1) == 0) ? CAM_SYNC : DISP_SYNC1);
                repeat (6) send_byte(BYTE_W'($urandom));
            end
        endcase
    endtask

    initial
    begin
        int pick;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
        begin
            send_byte(directed_bytes[i]);
        end

        while (frame_bytes_sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_display($urandom_range(0, 12));
            end
            else if (pick < 80)
            begin
                send_camera($urandom_range(0, 12));
            end
            else
            begin
                send_noise();
            end
        end

        rx_if.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("dual_header_frame_receiver_core regression: pass");
        end
        else
        begin
            $display("dual_header_frame_receiver_core regression: fail");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("dual_header_frame_receiver_core regression: fail");
        $finish;
    end

endmodule
